>>> rtl/reload_down_counter_timer_defines.svh
// Assertion macros for the reload down-counter timer.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef RELOAD_DOWN_COUNTER_TIMER_DEFINES_SVH
`define RELOAD_DOWN_COUNTER_TIMER_DEFINES_SVH

`ifndef ASSERT_OFF
// check prop on every rising edge, skipped while reset is held
`define RDCT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rdct assertion failed");
// check prop on every rising edge, reset included
`define RDCT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rdct assertion failed");
`else
`define RDCT_ASSERT(lbl, clk, rstn, prop)
`define RDCT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/rdct_pkg.sv
// Types and constants shared by the reload down-counter timer modules.
// No dependencies.
package rdct_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int WORD_WIDTH  = 32;
    localparam int READ_WIDTH  = 24;

    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = {COUNT_WIDTH{1'b1}};
    localparam logic [3:0] CTRL_RESET  = 4'h8;
    localparam logic [3:0] CTRL_STORED = 4'hd;

    localparam int CTRL_START = 0;
    localparam int CTRL_LOAD  = 1;
    localparam int CTRL_IRQEN = 2;
    localparam int CTRL_AUTO  = 3;

    localparam logic [1:0] REG_RELOAD = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_CTRL   = 2'd2;

    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [3:0]            address;
        logic [2:0]            access_size;
        logic [WORD_WIDTH-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic                  ok;
        logic [READ_WIDTH-1:0] read_data;
        logic                  irq_pulse;
    } t_result;

endpackage

>>> rtl/reload_down_counter_timer.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------------
// in       | input     | i_in_valid / o_in_ready | i_opcode i_address i_access_size i_write_data
// out      | output    | o_out_valid/ i_out_ready| o_ok o_read_data o_irq_pulse
//
// One item per cycle unless stalled; o_out_valid rises as an item enters the result register.
// Registers update as an item leaves the input register for the result register.
// Reset (i_rst_n low, synchronous) empties both registers, reload and counter
// to all ones, control to auto-reload only.
// A stall on out holds the result register; in keeps taking items until the
// input register is also full.
// Top level of the reload down-counter timer; depends on rdct_pkg and its modules.
module reload_down_counter_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_address,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [23:0] o_read_data,
    output logic        o_irq_pulse
);

    rdct_pkg::t_item   in_item;
    rdct_pkg::t_item   stg_item;
    rdct_pkg::t_result core_result;
    rdct_pkg::t_result out_result;
    logic              stg_vld;
    logic              out_rdy;
    logic              adv;

    assign in_item.opcode      = i_opcode;
    assign in_item.address     = i_address;
    assign in_item.access_size = i_access_size;
    assign in_item.write_data  = i_write_data;
    assign adv                 = stg_vld && out_rdy;

    rdct_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .i_take     (out_rdy),
        .o_vld      (stg_vld),
        .o_item     (stg_item)
    );

    rdct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (stg_item),
        .i_adv    (adv),
        .o_result (core_result)
    );

    rdct_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (stg_vld),
        .o_ready     (out_rdy),
        .i_result    (core_result),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (out_result)
    );

    assign o_ok        = out_result.ok;
    assign o_read_data = out_result.read_data;
    assign o_irq_pulse = out_result.irq_pulse;

endmodule

>>> rtl/rdct_in_stage.sv
// Input register of the reload down-counter timer: holds one item.
// Depends on rdct_pkg.
module rdct_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rdct_pkg::t_item     i_item,
    input  logic                i_take,
    output logic                o_vld,
    output rdct_pkg::t_item     o_item
);

    logic            r_vld;
    rdct_pkg::t_item r_item;

    assign o_in_ready = !r_vld || i_take;
    assign o_vld      = r_vld;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/rdct_core.sv
// Register file and tick logic of the reload down-counter timer.
// Depends on rdct_pkg and reload_down_counter_timer_defines.svh.
`include "reload_down_counter_timer_defines.svh"

module rdct_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rdct_pkg::t_item     i_item,
    input  logic                i_adv,
    output rdct_pkg::t_result   o_result
);

    logic [rdct_pkg::COUNT_WIDTH-1:0] r_reload, n_reload;
    logic [rdct_pkg::COUNT_WIDTH-1:0] r_count,  n_count;
    logic [3:0]                       r_ctrl,   n_ctrl;

    logic                             good;
    logic [rdct_pkg::WORD_WIDTH-1:0]  wval;
    logic [rdct_pkg::WORD_WIDTH-1:0]  rval;
    logic [rdct_pkg::WORD_WIDTH-1:0]  rsel;

    always_comb begin
        n_reload = r_reload;
        n_count  = r_count;
        n_ctrl   = r_ctrl;
        o_result = '0;
        rval     = '0;
        rsel     = '0;
        good     = (i_item.access_size inside {rdct_pkg::SIZE_HALF, rdct_pkg::SIZE_WORD})
                   && (i_item.address[1:0] == 2'b00);
        wval     = (i_item.access_size == rdct_pkg::SIZE_HALF)
                   ? {16'b0, i_item.write_data[15:0]} : i_item.write_data;
        case (i_item.opcode)
            rdct_pkg::OP_TICK: begin
                o_result.ok = 1'b1;
                if (r_ctrl[rdct_pkg::CTRL_START]) begin
                    if (r_count != '0) begin
                        n_count = r_count - rdct_pkg::COUNT_WIDTH'(1);
                    end else begin
                        if (r_ctrl[rdct_pkg::CTRL_AUTO]) begin
                            n_count = r_reload;
                        end else begin
                            n_ctrl[rdct_pkg::CTRL_START] = 1'b0;
                        end
                        o_result.irq_pulse = r_ctrl[rdct_pkg::CTRL_IRQEN];
                    end
                end
            end
            rdct_pkg::OP_READ: begin
                case (i_item.address[3:2])
                    rdct_pkg::REG_RELOAD: rval = rdct_pkg::WORD_WIDTH'(r_reload);
                    rdct_pkg::REG_COUNT:  rval = rdct_pkg::WORD_WIDTH'(r_count);
                    rdct_pkg::REG_CTRL:   rval = rdct_pkg::WORD_WIDTH'(r_ctrl);
                    default:              good = 1'b0;
                endcase
                rsel = (i_item.access_size == rdct_pkg::SIZE_HALF)
                       ? {16'b0, rval[15:0]} : rval;
                if (good) begin
                    o_result.ok        = 1'b1;
                    o_result.read_data = rsel[rdct_pkg::READ_WIDTH-1:0];
                end
            end
            rdct_pkg::OP_WRITE: begin
                if (good) begin
                    case (i_item.address[3:2])
                        rdct_pkg::REG_RELOAD: begin
                            n_reload = wval[rdct_pkg::COUNT_WIDTH-1:0];
                        end
                        rdct_pkg::REG_CTRL: begin
                            if (wval[rdct_pkg::CTRL_START] && !r_ctrl[rdct_pkg::CTRL_START]) begin
                                n_count = r_reload;
                            end
                            if (wval[rdct_pkg::CTRL_LOAD]) begin
                                n_count = r_reload;
                            end
                            n_ctrl = wval[3:0] & rdct_pkg::CTRL_STORED;
                        end
                        default: good = 1'b0;
                    endcase
                end
                o_result.ok = good;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= rdct_pkg::COUNT_RESET;
            r_count  <= rdct_pkg::COUNT_RESET;
            r_ctrl   <= rdct_pkg::CTRL_RESET;
        end else if (i_adv) begin
            r_reload <= n_reload;
            r_count  <= n_count;
            r_ctrl   <= n_ctrl;
        end
    end

    `RDCT_ASSERT(a_hold_when_idle, i_clk, i_rst_n,
        !i_adv |=> $stable(r_reload) && $stable(r_count) && $stable(r_ctrl))
    `RDCT_ASSERT(a_fail_no_effect, i_clk, i_rst_n,
        (i_adv && !o_result.ok) |=> $stable(r_reload) && $stable(r_count) && $stable(r_ctrl))
    `RDCT_ASSERT(a_tick_decrements, i_clk, i_rst_n,
        (i_adv && i_item.opcode == rdct_pkg::OP_TICK && r_ctrl[rdct_pkg::CTRL_START]
         && r_count != '0) |=> (r_count + rdct_pkg::COUNT_WIDTH'(1)) == $past(r_count))
    `RDCT_ASSERT(a_irq_only_on_expiry, i_clk, i_rst_n,
        (i_adv && o_result.irq_pulse) |-> (r_count == '0) && r_ctrl[rdct_pkg::CTRL_IRQEN])
    `RDCT_ASSERT(a_load_bit_not_stored, i_clk, i_rst_n,
        !r_ctrl[rdct_pkg::CTRL_LOAD])

endmodule

>>> rtl/rdct_out_stage.sv
// Result register of the reload down-counter timer: holds one finished item.
// Depends on rdct_pkg.
module rdct_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_ready,
    input  rdct_pkg::t_result   i_result,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rdct_pkg::t_result   o_result
);

    logic              r_vld;
    rdct_pkg::t_result r_result;

    assign o_ready     = !r_vld || i_out_ready;
    assign o_out_valid = r_vld;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_result <= i_result;
        end
    end

endmodule

>>> verif/reload_down_counter_timer_tb.sv
// Self-checking testbench for reload_down_counter_timer: register reads and writes,
// bad accesses and timer ticks, checked result by result against a built-in predictor.
// Depends on rdct_pkg and the reload_down_counter_timer RTL.
module reload_down_counter_timer_tb;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [3:0] ADDR_RELOAD = {rdct_pkg::REG_RELOAD, 2'b00};
    localparam logic [3:0] ADDR_COUNT  = {rdct_pkg::REG_COUNT, 2'b00};
    localparam logic [3:0] ADDR_CTRL   = {rdct_pkg::REG_CTRL, 2'b00};
    localparam logic [3:0] ADDR_HOLE   = 4'hc;
    localparam logic [2:0] SIZE_BYTE   = 3'd1;

    localparam int ITEM_COUNT  = 1750;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 40;
    localparam int PAUSE_AT    = 900;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = '0;
    logic [3:0]  i_address = '0;
    logic [2:0]  i_access_size = '0;
    logic [31:0] i_write_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_ok;
    logic [23:0] o_read_data;
    logic        o_irq_pulse;

    rdct_pkg::t_item   item_backlog[$];
    rdct_pkg::t_result pending_results[$];

    logic [rdct_pkg::COUNT_WIDTH-1:0] shadow_reload = rdct_pkg::COUNT_RESET;
    logic [rdct_pkg::COUNT_WIDTH-1:0] shadow_count = rdct_pkg::COUNT_RESET;
    logic [3:0]                       shadow_ctrl = rdct_pkg::CTRL_RESET;

    int n_total = 0;
    int n_offered = 0;
    int n_accepted = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int mismatches = 0;
    int cycles = 0;

    reload_down_counter_timer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_access_size(i_access_size),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ok         (o_ok),
        .o_read_data  (o_read_data),
        .o_irq_pulse  (o_irq_pulse)
    );

    function automatic rdct_pkg::t_result timer_next_result(rdct_pkg::t_item it);
        rdct_pkg::t_result r;
        logic              wr;
        logic              good;
        logic [31:0]       val;
        r = '0;
        if (it.opcode == rdct_pkg::OP_TICK) begin
            r.ok = 1'b1;
            if (shadow_ctrl[rdct_pkg::CTRL_START]) begin
                if (shadow_count != '0) begin
                    shadow_count = shadow_count - rdct_pkg::COUNT_WIDTH'(1);
                end else begin
                    if (shadow_ctrl[rdct_pkg::CTRL_AUTO]) begin
                        shadow_count = shadow_reload;
                    end else begin
                        shadow_ctrl[rdct_pkg::CTRL_START] = 1'b0;
                    end
                    r.irq_pulse = shadow_ctrl[rdct_pkg::CTRL_IRQEN];
                end
            end
        end else if (it.opcode == rdct_pkg::OP_READ || it.opcode == rdct_pkg::OP_WRITE) begin
            wr = (it.opcode == rdct_pkg::OP_WRITE);
            good = (it.access_size == rdct_pkg::SIZE_HALF ||
                    it.access_size == rdct_pkg::SIZE_WORD) &&
                   it.address[1:0] == 2'b00;
            val = (it.access_size == rdct_pkg::SIZE_HALF) ? {16'h0, it.write_data[15:0]}
                                                          : it.write_data;
            if (good) begin
                case (it.address[3:2])
                    rdct_pkg::REG_RELOAD: begin
                        if (wr) shadow_reload = val[rdct_pkg::COUNT_WIDTH-1:0];
                        else val = 32'(shadow_reload);
                    end
                    rdct_pkg::REG_COUNT: begin
                        if (wr) good = 1'b0;
                        else val = 32'(shadow_count);
                    end
                    rdct_pkg::REG_CTRL: begin
                        if (wr) begin
                            if (val[rdct_pkg::CTRL_START] &&
                                !shadow_ctrl[rdct_pkg::CTRL_START]) begin
                                shadow_count = shadow_reload;
                            end
                            shadow_ctrl = val[3:0] & rdct_pkg::CTRL_STORED;
                            if (val[rdct_pkg::CTRL_LOAD]) shadow_count = shadow_reload;
                        end else begin
                            val = {28'h0, shadow_ctrl};
                        end
                    end
                    default: good = 1'b0;
                endcase
            end
            if (good) begin
                r.ok = 1'b1;
                if (!wr) begin
                    r.read_data = (it.access_size == rdct_pkg::SIZE_HALF)
                                  ? {8'h0, val[15:0]} : val[rdct_pkg::READ_WIDTH-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic add_access(logic [1:0] op, logic [3:0] addr, logic [2:0] size,
                              logic [31:0] data);
        rdct_pkg::t_item it;
        it.opcode = op;
        it.address = addr;
        it.access_size = size;
        it.write_data = data;
        item_backlog.push_back(it);
    endtask

    task automatic add_tick();
        add_access(rdct_pkg::OP_TICK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                   $urandom);
    endtask

    task automatic add_ctrl_write(bit want_start);
        logic [31:0] data;
        data = $urandom;
        data[rdct_pkg::CTRL_START] = want_start;
        add_access(rdct_pkg::OP_WRITE, ADDR_CTRL,
                   ($urandom_range(0, 3) == 0) ? rdct_pkg::SIZE_HALF : rdct_pkg::SIZE_WORD,
                   data);
    endtask

    task automatic add_timer_run();
        logic [31:0] data;
        int          n_ticks;
        logic [3:0]  addr;
        data = $urandom;
        if ($urandom_range(0, 3) != 0) data[23:0] = 24'($urandom_range(0, 6));
        add_access(rdct_pkg::OP_WRITE, ADDR_RELOAD,
                   ($urandom_range(0, 3) == 0) ? rdct_pkg::SIZE_HALF : rdct_pkg::SIZE_WORD,
                   data);
        if ($urandom_range(0, 2) == 0) add_ctrl_write(1'b0);
        add_ctrl_write($urandom_range(0, 4) != 0);
        n_ticks = $urandom_range(1, 14);
        repeat (n_ticks) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0: addr = ADDR_RELOAD;
                    1: addr = ADDR_COUNT;
                    default: addr = ADDR_CTRL;
                endcase
                add_access(rdct_pkg::OP_READ, addr,
                           $urandom_range(0, 1) ? rdct_pkg::SIZE_HALF : rdct_pkg::SIZE_WORD,
                           $urandom);
            end
            if ($urandom_range(0, 19) == 0) add_ctrl_write(1'($urandom_range(0, 1)));
            add_tick();
        end
    endtask

    task automatic report_mismatch(string what, rdct_pkg::t_result want,
                                   rdct_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected ok=%0d read_data=%06h irq_pulse=%0d, %s%0d %s%06h %s%0d",
                     what, want.ok, want.read_data, want.irq_pulse,
                     "got ok=", got.ok, "read_data=", got.read_data,
                     "irq_pulse=", got.irq_pulse);
        end
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        // reset state, then every kind of bad access
        add_access(rdct_pkg::OP_READ, ADDR_RELOAD, rdct_pkg::SIZE_WORD, '0);
        add_access(rdct_pkg::OP_READ, ADDR_COUNT, rdct_pkg::SIZE_HALF, '0);
        add_access(rdct_pkg::OP_READ, ADDR_CTRL, rdct_pkg::SIZE_WORD, '0);
        add_access(rdct_pkg::OP_READ, ADDR_HOLE, rdct_pkg::SIZE_WORD, '0);
        add_access(rdct_pkg::OP_READ, 4'h1, rdct_pkg::SIZE_WORD, '0);
        add_access(rdct_pkg::OP_READ, ADDR_RELOAD, SIZE_BYTE, '0);
        add_access(rdct_pkg::OP_READ, ADDR_RELOAD, 3'd3, '0);
        add_access(rdct_pkg::OP_READ, ADDR_CTRL, 3'd0, '0);
        add_access(rdct_pkg::OP_WRITE, 4'hf, 3'd7, 32'hffff_ffff);
        add_access(rdct_pkg::OP_WRITE, ADDR_COUNT, rdct_pkg::SIZE_WORD, 32'h0000_0005);
        add_access(OP_UNUSED, 4'hf, 3'd7, 32'hffff_ffff);
        // one-shot expiry with interrupt
        add_access(rdct_pkg::OP_WRITE, ADDR_RELOAD, rdct_pkg::SIZE_HALF, 32'hffff_0002);
        add_access(rdct_pkg::OP_WRITE, ADDR_CTRL, rdct_pkg::SIZE_WORD, 32'h0000_0005);
        repeat (5) add_tick();
        add_access(rdct_pkg::OP_READ, ADDR_CTRL, rdct_pkg::SIZE_HALF, '0);
        // auto-reload of zero
        add_access(rdct_pkg::OP_WRITE, ADDR_RELOAD, rdct_pkg::SIZE_WORD, 32'h0000_0000);
        add_access(rdct_pkg::OP_WRITE, ADDR_CTRL, rdct_pkg::SIZE_WORD, 32'hffff_fff0 | 32'hf);
        repeat (2) add_tick();
        add_access(rdct_pkg::OP_WRITE, ADDR_RELOAD, rdct_pkg::SIZE_WORD, 32'hffff_ffff);
        add_access(rdct_pkg::OP_WRITE, ADDR_CTRL, rdct_pkg::SIZE_WORD, 32'h0000_0002);
        add_access(rdct_pkg::OP_READ, ADDR_COUNT, rdct_pkg::SIZE_WORD, '0);
        add_tick();

        while (item_backlog.size() < ITEM_COUNT) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    add_access(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                               3'($urandom_range(0, 7)), $urandom);
                end
            end else begin
                add_timer_run();
            end
        end
        n_total = item_backlog.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_backlog.size() != 0 || i_in_valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("reload_down_counter_timer_tb passed");
        end else begin
            $display("reload_down_counter_timer_tb failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drive_items
        logic            fire;
        bit              calm;
        rdct_pkg::t_item nxt;
        fire = i_in_valid && o_in_ready;
        calm = (n_accepted % 300) >= 240;
        if (fire) begin
            nxt.opcode = i_opcode;
            nxt.address = i_address;
            nxt.access_size = i_access_size;
            nxt.write_data = i_write_data;
            pending_results.push_back(timer_next_result(nxt));
            n_accepted <= n_accepted + 1;
        end
        if (i_rst_n && (!i_in_valid || fire)) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (item_backlog.size() == 0 ||
                         (n_offered == PAUSE_AT && pending_results.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = item_backlog.pop_front();
                i_opcode <= nxt.opcode;
                i_address <= nxt.address;
                i_access_size <= nxt.access_size;
                i_write_data <= nxt.write_data;
                i_in_valid <= 1'b1;
                n_offered <= n_offered + 1;
                if (!calm && item_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge i_clk) begin : pace_receiver
        bit calm;
        calm = (n_accepted % 300) >= 240 || n_accepted + QUIET_TAIL >= n_total;
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            // hold off long enough for the block to fill and stall its input
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        rdct_pkg::t_result got;
        rdct_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.ok = o_ok;
            got.read_data = o_read_data;
            got.irq_pulse = o_irq_pulse;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok || got.read_data !== want.read_data ||
                    got.irq_pulse !== want.irq_pulse) begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("reload_down_counter_timer_tb failed");
            $finish;
        end
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rdct_pkg.sv
rtl/rdct_in_stage.sv
rtl/rdct_core.sv
rtl/rdct_out_stage.sv
rtl/reload_down_counter_timer.sv
verif/reload_down_counter_timer_tb.sv
